@@ rtl/core/gpcf_pkg.sv @@
// ----------------------------------------------------------------------------
// Gimbal PID command framer package
// Shared constants, register indexes and control types.
// ----------------------------------------------------------------------------
package gpcf_pkg;

   localparam int GainFracBitsDefault = 8;

   localparam int GainWidth   = 16;
   localparam int FieldWidth  = 16;
   localparam int LimitWidth  = 14;
   localparam int ProdWidth   = 32;
   localparam int SumWidth    = 34;
   localparam int ClampWidth  = 15;
   localparam int CmdWidth    = 16;
   localparam int IndexWidth  = 4;
   localparam int FrameLen    = 8;
   localparam int ByteIdxWidth = 3;

   localparam logic [IndexWidth-1:0] REG_YAW_PROP    = 4'd0;
   localparam logic [IndexWidth-1:0] REG_YAW_DERIV   = 4'd1;
   localparam logic [IndexWidth-1:0] REG_YAW_INTEG   = 4'd2;
   localparam logic [IndexWidth-1:0] REG_PITCH_PROP  = 4'd3;
   localparam logic [IndexWidth-1:0] REG_PITCH_DERIV = 4'd4;
   localparam logic [IndexWidth-1:0] REG_PITCH_INTEG = 4'd5;
   localparam logic [IndexWidth-1:0] REG_DRIVE_LIMIT = 4'd6;
   localparam logic [IndexWidth-1:0] REG_DEADBAND    = 4'd7;

   localparam logic signed [GainWidth-1:0] PropGainReset  = 16'sd1664;
   localparam logic signed [GainWidth-1:0] DerivGainReset = 16'sd36;
   localparam logic signed [GainWidth-1:0] IntegGainReset = 16'sd0;
   localparam logic [LimitWidth-1:0]       LimitReset     = 14'd500;
   localparam logic [LimitWidth-1:0]       OffsetReset    = 14'd50;

   localparam logic [7:0] SYNC_BYTE = 8'h55;
   localparam logic [7:0] CMD_BYTE  = 8'h01;
   localparam logic [7:0] TAIL_BYTE = 8'h02;

   localparam logic [ByteIdxWidth-1:0] LastByteIdx = 3'(FrameLen - 1);

   typedef struct packed {
      logic signed [GainWidth-1:0] kp;
      logic signed [GainWidth-1:0] kd;
      logic signed [GainWidth-1:0] ki;
   } axis_gain_type;

   typedef struct packed {
      axis_gain_type               yaw;
      axis_gain_type               pitch;
      logic [LimitWidth-1:0]       limit;
      logic [LimitWidth-1:0]       offset;
   } cfg_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

endpackage

@@ rtl/core/gpcf_csr.sv @@
// ----------------------------------------------------------------------------
// Gimbal PID command framer register file
// Holds the axis gains, the drive limit and the deadband offset.
// ----------------------------------------------------------------------------
module gpcf_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [gpcf_pkg::IndexWidth-1:0]      csr_index,
   input  logic [gpcf_pkg::GainWidth-1:0]       csr_wdata,
   output gpcf_pkg::cfg_type                    cfg
);

   gpcf_pkg::cfg_type cfg_ff;
   gpcf_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            gpcf_pkg::REG_YAW_PROP:    cfg_in.yaw.kp   = csr_wdata;
            gpcf_pkg::REG_YAW_DERIV:   cfg_in.yaw.kd   = csr_wdata;
            gpcf_pkg::REG_YAW_INTEG:   cfg_in.yaw.ki   = csr_wdata;
            gpcf_pkg::REG_PITCH_PROP:  cfg_in.pitch.kp = csr_wdata;
            gpcf_pkg::REG_PITCH_DERIV: cfg_in.pitch.kd = csr_wdata;
            gpcf_pkg::REG_PITCH_INTEG: cfg_in.pitch.ki = csr_wdata;
            gpcf_pkg::REG_DRIVE_LIMIT:
               cfg_in.limit = csr_wdata[gpcf_pkg::LimitWidth-1:0];
            gpcf_pkg::REG_DEADBAND:
               cfg_in.offset = csr_wdata[gpcf_pkg::LimitWidth-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.yaw.kp   <= gpcf_pkg::PropGainReset;
         cfg_ff.yaw.kd   <= gpcf_pkg::DerivGainReset;
         cfg_ff.yaw.ki   <= gpcf_pkg::IntegGainReset;
         cfg_ff.pitch.kp <= gpcf_pkg::PropGainReset;
         cfg_ff.pitch.kd <= gpcf_pkg::DerivGainReset;
         cfg_ff.pitch.ki <= gpcf_pkg::IntegGainReset;
         cfg_ff.limit    <= gpcf_pkg::LimitReset;
         cfg_ff.offset   <= gpcf_pkg::OffsetReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/gpcf_axis.sv @@
// ----------------------------------------------------------------------------
// Gimbal PID command framer axis datapath
// Four register stages: products, scaled sum, clamp, deadband offset.
// ----------------------------------------------------------------------------
module gpcf_axis #(
   parameter int GAIN_FRAC_BITS = gpcf_pkg::GainFracBitsDefault
) (
   input  logic                                   clock,
   input  gpcf_pkg::stage_en_type                 en,
   input  gpcf_pkg::axis_gain_type                gain,
   input  logic        [gpcf_pkg::LimitWidth-1:0] limit,
   input  logic        [gpcf_pkg::LimitWidth-1:0] offset,
   input  logic signed [gpcf_pkg::FieldWidth-1:0] err,
   input  logic signed [gpcf_pkg::FieldWidth-1:0] rate,
   input  logic signed [gpcf_pkg::FieldWidth-1:0] accum,
   output logic        [gpcf_pkg::CmdWidth-1:0]   cmd
);

   localparam int Sw = gpcf_pkg::SumWidth;
   localparam logic [Sw-1:0] RoundBias = (Sw'(1) << GAIN_FRAC_BITS) - Sw'(1);

   logic signed [gpcf_pkg::ProdWidth-1:0] p_prop_ff, p_deriv_ff, p_integ_ff;
   logic signed [gpcf_pkg::ProdWidth-1:0] p_prop_in, p_deriv_in, p_integ_in;
   logic signed [Sw-1:0]                  quot_ff, quot_in, sum_w, biased_w;
   logic signed [gpcf_pkg::ClampWidth-1:0] clamp_ff, clamp_in;
   logic signed [gpcf_pkg::CmdWidth-1:0]   cmd_ff, cmd_in;
   logic signed [Sw-1:0]                  lim_pos, lim_neg;
   logic signed [gpcf_pkg::CmdWidth-1:0]  clamp_ext, off_ext;

   always_comb begin
      p_prop_in  = gain.kp * err;
      p_deriv_in = gain.kd * rate;
      p_integ_in = gain.ki * accum;
   end

   always_comb begin
      sum_w = Sw'(p_prop_ff) + Sw'(p_deriv_ff) + Sw'(p_integ_ff);
      biased_w = sum_w[Sw-1] ? (sum_w + $signed(RoundBias)) : sum_w;
      quot_in = biased_w >>> GAIN_FRAC_BITS;
   end

   always_comb begin
      lim_pos = $signed({{(Sw - gpcf_pkg::LimitWidth){1'b0}}, limit});
      lim_neg = -lim_pos;
      if (quot_ff > lim_pos) begin
         clamp_in = lim_pos[gpcf_pkg::ClampWidth-1:0];
      end else if (quot_ff < lim_neg) begin
         clamp_in = lim_neg[gpcf_pkg::ClampWidth-1:0];
      end else begin
         clamp_in = quot_ff[gpcf_pkg::ClampWidth-1:0];
      end
   end

   always_comb begin
      clamp_ext = gpcf_pkg::CmdWidth'(clamp_ff);
      off_ext = $signed({{(gpcf_pkg::CmdWidth - gpcf_pkg::LimitWidth){1'b0}}, offset});
      if (clamp_ext > 0) begin
         cmd_in = clamp_ext + off_ext;
      end else begin
         cmd_in = clamp_ext - off_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         p_prop_ff  <= p_prop_in;
         p_deriv_ff <= p_deriv_in;
         p_integ_ff <= p_integ_in;
      end
      if (en.s2) begin
         quot_ff <= quot_in;
      end
      if (en.s3) begin
         clamp_ff <= clamp_in;
      end
      if (en.s4) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd = cmd_ff;

endmodule

@@ rtl/core/gpcf_serializer.sv @@
// ----------------------------------------------------------------------------
// Gimbal PID command framer serializer
// Builds the eight-byte frame with its checksum and sends it one byte a cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module gpcf_serializer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load_valid,
   output logic                              load_ready,
   input  logic                              seen,
   input  logic [gpcf_pkg::CmdWidth-1:0]     yaw_cmd,
   input  logic [gpcf_pkg::CmdWidth-1:0]     pitch_cmd,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_frame_byte,
   output logic                              rsp_frame_end
);

   logic [7:0] frame_ff [gpcf_pkg::FrameLen];
   logic [7:0] frame_in [gpcf_pkg::FrameLen];
   logic [gpcf_pkg::ByteIdxWidth-1:0] idx_ff, idx_in;
   logic busy_ff, busy_in;
   logic last_w, load_w;
   logic [gpcf_pkg::CmdWidth-1:0] yaw_w, pitch_w;

   assign last_w     = (idx_ff == gpcf_pkg::LastByteIdx);
   assign load_ready = !busy_ff || (rsp_ready && last_w);
   assign load_w     = load_valid && load_ready;

   always_comb begin
      yaw_w   = seen ? yaw_cmd : '0;
      pitch_w = seen ? pitch_cmd : '0;
      frame_in[0] = gpcf_pkg::SYNC_BYTE;
      frame_in[1] = gpcf_pkg::CMD_BYTE;
      frame_in[2] = yaw_w[7:0];
      frame_in[3] = yaw_w[15:8];
      frame_in[4] = pitch_w[7:0];
      frame_in[5] = pitch_w[15:8];
      frame_in[6] = gpcf_pkg::TAIL_BYTE;
      frame_in[7] = gpcf_pkg::SYNC_BYTE + gpcf_pkg::CMD_BYTE + gpcf_pkg::TAIL_BYTE
                    + yaw_w[7:0] + yaw_w[15:8] + pitch_w[7:0] + pitch_w[15:8];
   end

   always_comb begin
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (busy_ff && rsp_ready) begin
         idx_in = idx_ff + 1'b1;
         if (last_w) begin
            busy_in = 1'b0;
         end
      end
      if (load_w) begin
         idx_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_w) begin
         frame_ff <= frame_in;
      end
   end

   assign rsp_valid      = busy_ff;
   assign rsp_frame_byte = frame_ff[idx_ff];
   assign rsp_frame_end  = last_w;

endmodule

@@ rtl/core/gimbal_pid_command_framer_unit.sv @@
// ----------------------------------------------------------------------------
// Gimbal PID command framer
// PID command for yaw and pitch, clamped and offset, sent as an 8-byte frame.
// ----------------------------------------------------------------------------
// Each accepted word yields eight result words: 0x55, 0x01, yaw low, yaw high,
// pitch low, pitch high, 0x02 and the byte-sum checksum, the last one flagged
// by rsp_frame_end. Without a target the fixed idle frame is sent. The axis
// math runs through four register stages and the serializer registers the frame
// before its first byte shows. The serializer sends one byte per cycle while
// rsp_ready is high and takes the next word as the last byte of a frame goes;
// the pipeline holds up to four more words while a frame goes out. The user
// must write configuration only while idle; the block does not enforce it.
module gimbal_pid_command_framer_unit #(
   parameter int GAIN_FRAC_BITS = gpcf_pkg::GainFracBitsDefault
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [gpcf_pkg::IndexWidth-1:0]        csr_index,
   input  logic [gpcf_pkg::GainWidth-1:0]         csr_wdata,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [gpcf_pkg::FieldWidth-1:0] req_yaw_error,
   input  logic signed [gpcf_pkg::FieldWidth-1:0] req_pitch_error,
   input  logic signed [gpcf_pkg::FieldWidth-1:0] req_yaw_rate,
   input  logic signed [gpcf_pkg::FieldWidth-1:0] req_pitch_rate,
   input  logic signed [gpcf_pkg::FieldWidth-1:0] req_yaw_accum,
   input  logic signed [gpcf_pkg::FieldWidth-1:0] req_pitch_accum,
   input  logic                                   req_target_seen,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [7:0]                             rsp_frame_byte,
   output logic                                   rsp_frame_end
);

   gpcf_pkg::cfg_type      cfg;
   gpcf_pkg::stage_en_type en;
   logic [gpcf_pkg::CmdWidth-1:0] yaw_cmd, pitch_cmd;
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic s1_ff, s2_ff, s3_ff, s4_ff;
   logic ser_ready;

   assign csr_ready = 1'b1;

   gpcf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   always_comb begin
      en.s4 = !v4_ff || ser_ready;
      en.s3 = !v3_ff || en.s4;
      en.s2 = !v2_ff || en.s3;
      en.s1 = !v1_ff || en.s2;
   end

   assign req_ready = en.s1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en.s1) v1_ff <= req_valid;
         if (en.s2) v2_ff <= v1_ff;
         if (en.s3) v3_ff <= v2_ff;
         if (en.s4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) s1_ff <= req_target_seen;
      if (en.s2) s2_ff <= s1_ff;
      if (en.s3) s3_ff <= s2_ff;
      if (en.s4) s4_ff <= s3_ff;
   end

   gpcf_axis #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_yaw (
      .clock  (clock),
      .en     (en),
      .gain   (cfg.yaw),
      .limit  (cfg.limit),
      .offset (cfg.offset),
      .err    (req_yaw_error),
      .rate   (req_yaw_rate),
      .accum  (req_yaw_accum),
      .cmd    (yaw_cmd)
   );

   gpcf_axis #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_pitch (
      .clock  (clock),
      .en     (en),
      .gain   (cfg.pitch),
      .limit  (cfg.limit),
      .offset (cfg.offset),
      .err    (req_pitch_error),
      .rate   (req_pitch_rate),
      .accum  (req_pitch_accum),
      .cmd    (pitch_cmd)
   );

   gpcf_serializer u_ser (
      .clock          (clock),
      .reset          (reset),
      .load_valid     (v4_ff),
      .load_ready     (ser_ready),
      .seen           (s4_ff),
      .yaw_cmd        (yaw_cmd),
      .pitch_cmd      (pitch_cmd),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_frame_end  (rsp_frame_end)
   );

`ifndef SYNTHESIS
   a_accept_fills_stage1: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v1_ff)
      else $error("accepted word did not reach the first stage");

   a_stage4_holds: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !ser_ready) |=> (v4_ff && $stable(yaw_cmd) && $stable(pitch_cmd)))
      else $error("stalled last stage lost its word");

   a_frame_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_frame_end && !v4_ff) |=> !rsp_valid)
      else $error("serializer kept sending after the frame ended");

   a_frame_starts_sync: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_frame_end) |=>
      (!rsp_valid || rsp_frame_byte == gpcf_pkg::SYNC_BYTE))
      else $error("frame did not start with the sync byte");
`endif

endmodule
